FILE: hdl/scfkm_pkg.sv
`default_nettype none

package scfkm_pkg;

  // request kinds carried in the mode field
  localparam logic [1:0] MODE_SCAN = 2'd0;
  localparam logic [1:0] MODE_POP  = 2'd1;
  localparam logic [1:0] MODE_TEST = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_LEFT_SHIFT  = 2'd0;
  localparam logic [1:0] CFG_RIGHT_SHIFT = 2'd1;
  localparam logic [1:0] CFG_LEFT_ALT    = 2'd2;
  localparam logic [1:0] CFG_LEFT_CTRL   = 2'd3;

  localparam logic [7:0] LEFT_SHIFT_RST  = 8'd42;
  localparam logic [7:0] RIGHT_SHIFT_RST = 8'd54;
  localparam logic [7:0] LEFT_ALT_RST    = 8'd56;
  localparam logic [7:0] LEFT_CTRL_RST   = 8'd29;

  localparam logic [7:0] PREFIX_CODE = 8'hE0;

  localparam int unsigned KEY_COUNT = 128;
  localparam int unsigned KEY_W     = 7;
  localparam int unsigned FILL_W    = 5;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  typedef struct packed {
    logic [1:0]       mode;
    logic [7:0]       code;
    logic [KEY_W-1:0] key;
    logic             filtered;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hdl/scfkm_ram.sv
`default_nettype none

module scfkm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/scfkm_front.sv
`default_nettype none

module scfkm_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [7:0]           cfg_wdata_i,
  input  wire logic [1:0]           mode_i,
  input  wire logic [7:0]           scan_code_i,
  input  wire logic [6:0]           test_key_i,
  output scfkm_pkg::cmd_t           cmd_o
);

  import scfkm_pkg::*;

  logic [7:0] lshift_q, rshift_q, lalt_q, lctrl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lshift_q <= LEFT_SHIFT_RST;
      rshift_q <= RIGHT_SHIFT_RST;
      lalt_q   <= LEFT_ALT_RST;
      lctrl_q  <= LEFT_CTRL_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LEFT_SHIFT:  lshift_q <= cfg_wdata_i;
        CFG_RIGHT_SHIFT: rshift_q <= cfg_wdata_i;
        CFG_LEFT_ALT:    lalt_q   <= cfg_wdata_i;
        CFG_LEFT_CTRL:   lctrl_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // modifier make codes and the extended prefix never enter the fifo
  always_comb begin
    cmd_o.mode     = mode_i;
    cmd_o.code     = scan_code_i;
    cmd_o.key      = test_key_i;
    cmd_o.filtered = (scan_code_i == lshift_q) || (scan_code_i == rshift_q) ||
                     (scan_code_i == lalt_q) || (scan_code_i == lctrl_q) ||
                     (scan_code_i == PREFIX_CODE);
  end

endmodule

`default_nettype wire

FILE: hdl/scfkm_queue.sv
`default_nettype none

module scfkm_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  scfkm_pkg::cmd_t      push_cmd_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output scfkm_pkg::cmd_t      pop_cmd_o,
  output logic                 empty_o
);

  import scfkm_pkg::*;

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign pop_cmd_o = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/scfkm_back.sv
`default_nettype none

module scfkm_back #(
  parameter int unsigned FIFO_DEPTH = 16,
  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_empty_i,
  input  scfkm_pkg::cmd_t      q_cmd_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [7:0]           popped_code_o,
  output logic                 key_down_o,
  output logic                 code_queued_o,
  output logic                 overflow_o,
  output logic [4:0]           fill_level_o
);

  import scfkm_pkg::*;

  logic                 issue;
  logic [PTR_W-1:0]     rp_q, rp_d, wp_q, wp_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [KEY_COUNT-1:0] map_vld_q, map_vld_d;

  logic                 code_we;
  logic [7:0]           code_rdata;
  logic                 map_we;
  logic                 map_rdata;

  // per-request flags held while the ram read completes
  logic                 pend_q;
  logic                 hit_q, hit_d;
  logic                 test_q, test_d;
  logic                 kvld_q;
  logic                 queued_q, queued_d;
  logic                 ovf_q, ovf_d;
  logic [CNT_W+FILL_W-1:0] fill_ext;
  logic [FILL_W-1:0]    fill_q;

  logic                 out_valid_q;
  logic [7:0]           popped_q;
  logic                 down_q;
  logic                 oq_q;
  logic                 oovf_q;
  logic [FILL_W-1:0]    ofill_q;

  assign issue   = !q_empty_i && !pend_q && (!out_valid_q || out_ready_i);
  assign q_pop_o = issue;

  always_comb begin
    rp_d      = rp_q;
    wp_d      = wp_q;
    cnt_d     = cnt_q;
    map_vld_d = map_vld_q;
    code_we   = 1'b0;
    map_we    = 1'b0;
    hit_d     = 1'b0;
    test_d    = 1'b0;
    queued_d  = 1'b0;
    ovf_d     = 1'b0;
    if (issue) begin
      case (q_cmd_i.mode)
        MODE_SCAN: begin
          map_we = 1'b1;
          map_vld_d[q_cmd_i.code[KEY_W-1:0]] = 1'b1;
          if (!q_cmd_i.filtered) begin
            if (cnt_q == CNT_W'(FIFO_DEPTH)) begin
              ovf_d = 1'b1;
            end else begin
              code_we  = 1'b1;
              queued_d = 1'b1;
              cnt_d    = cnt_q + 1'b1;
              wp_d     = (wp_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wp_q + 1'b1;
            end
          end
        end
        MODE_POP: begin
          if (cnt_q != '0) begin
            hit_d = 1'b1;
            cnt_d = cnt_q - 1'b1;
            rp_d  = (rp_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rp_q + 1'b1;
          end
        end
        MODE_TEST: test_d = 1'b1;
        default: ;
      endcase
    end
  end

  assign fill_ext = {{FILL_W{1'b0}}, cnt_d};

  scfkm_ram #(
    .WIDTH(8),
    .DEPTH(FIFO_DEPTH)
  ) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (code_we),
    .waddr_i (wp_q),
    .wdata_i (q_cmd_i.code),
    .raddr_i (rp_q),
    .rdata_o (code_rdata)
  );

  // map bits live in ram, a cleared valid bit reads as key up
  scfkm_ram #(
    .WIDTH(1),
    .DEPTH(KEY_COUNT)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (q_cmd_i.code[KEY_W-1:0]),
    .wdata_i (!q_cmd_i.code[7]),
    .raddr_i (q_cmd_i.key),
    .rdata_o (map_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q        <= '0;
      wp_q        <= '0;
      cnt_q       <= '0;
      map_vld_q   <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rp_q      <= rp_d;
      wp_q      <= wp_d;
      cnt_q     <= cnt_d;
      map_vld_q <= map_vld_d;
      pend_q    <= issue;
      if (pend_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      hit_q    <= hit_d;
      test_q   <= test_d;
      kvld_q   <= map_vld_q[q_cmd_i.key];
      queued_q <= queued_d;
      ovf_q    <= ovf_d;
      fill_q   <= fill_ext[FILL_W-1:0];
    end
    if (pend_q) begin
      popped_q <= hit_q ? code_rdata : 8'h00;
      down_q   <= test_q && kvld_q && map_rdata;
      oq_q     <= queued_q;
      oovf_q   <= ovf_q;
      ofill_q  <= fill_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign popped_code_o = popped_q;
  assign key_down_o    = down_q;
  assign code_queued_o = oq_q;
  assign overflow_o    = oovf_q;
  assign fill_level_o  = ofill_q;

endmodule

`default_nettype wire

FILE: hdl/scan_code_fifo_with_key_map_unit.sv
`default_nettype none

// channel   handshake                fields
// config    cfg_we_i                 cfg_index_i, cfg_wdata_i
// request   in_valid_i / in_ready_o  mode_i, scan_code_i, test_key_i
// result    out_valid_o / out_ready_i popped_code_o, key_down_o, code_queued_o,
//                                    overflow_o, fill_level_o
//
// a request sits in a two-entry queue, then goes through the back end in order:
// first the pointers are updated and the ram reads issued, then the registered read
// data is taken into the result; no new request issues while one is still pending.
// reset clears all pointers and the key map valid bits at once, no sweep.
// a stalled result holds the back end; the queue keeps taking up to two requests.

module scan_code_fifo_with_key_map_unit #(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] mode_i,
  input  wire logic [7:0] scan_code_i,
  input  wire logic [6:0] test_key_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      popped_code_o,
  output logic            key_down_o,
  output logic            code_queued_o,
  output logic            overflow_o,
  output logic [4:0]      fill_level_o
);

  import scfkm_pkg::*;

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic q_full, q_empty, q_pop;

  assign in_ready_o = !q_full;

  scfkm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mode_i      (mode_i),
    .scan_code_i (scan_code_i),
    .test_key_i  (test_key_i),
    .cmd_o       (front_cmd)
  );

  scfkm_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_valid_i && !q_full),
    .push_cmd_i (front_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .pop_cmd_o  (back_cmd),
    .empty_o    (q_empty)
  );

  scfkm_back #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_cmd_i       (back_cmd),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .popped_code_o (popped_code_o),
    .key_down_o    (key_down_o),
    .code_queued_o (code_queued_o),
    .overflow_o    (overflow_o),
    .fill_level_o  (fill_level_o)
  );

endmodule

`default_nettype wire
